@@ rtl/core/tibu_pkg.sv @@
// Shared types and constants for the tiled icon bilinear upscaler.
package tibu_pkg;

	localparam logic [1:0] KIND_BITMAP  = 2'd0;
	localparam logic [1:0] KIND_PALETTE = 2'd1;
	localparam logic [1:0] KIND_PIXEL   = 2'd2;

	localparam logic [5:0] DEST_LAST = 6'd47;
	localparam logic [4:0] SRC_LAST  = 5'd31;

	// floor(s/3) = (s*171) >> 9 for s <= 94
	localparam logic [7:0] RECIP3 = 8'd171;
	// floor(v/9) = (v*57) >> 9 for v <= 279
	localparam logic [5:0] RECIP9 = 6'd57;

	// four neighbors, order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
	typedef logic [3:0][3:0]  nbr_idx_t;
	typedef logic [3:0][14:0] nbr_color_t;

	typedef struct packed {
		logic       wr_en;
		logic [8:0] wr_addr;
		logic [7:0] wr_data;
		logic [4:0] x0;
		logic [4:0] x1;
		logic [4:0] y0;
		logic [4:0] y1;
	} bm_cmd_t;

	typedef struct packed {
		logic        wr_en;
		logic [3:0]  wr_addr;
		logic [14:0] wr_data;
	} pal_wr_t;

endpackage

@@ rtl/core/tiled_icon_bilinear_upscale.sv @@
// Top level: 32x32 paletted icon upscaled bilinearly to 48x48, one pixel per item.
// One item enters per cycle unless in_stall is high; a pixel result passes through
// five register stages (coordinate map, bitmap read, palette read, weighted sum,
// divide and output register). Throughput is set by the bitmap's four banks and the
// four palette copies, each serving one neighbor read per cycle while its stage
// advances. Bitmap and palette writes take effect in pipeline order with the
// requests around them and give no result. A stall on the output holds only the
// stages that are full; empty stages keep filling. There are no configuration
// registers.
module tiled_icon_bilinear_upscale import tibu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [8:0]  address,
	input  logic [15:0] data,
	input  logic [5:0]  dest_x,
	input  logic [5:0]  dest_y,
	input  logic        flip_h,
	input  logic        flip_v,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] out_index,
	output logic [7:0]  blue_byte,
	output logic [7:0]  green_byte,
	output logic [7:0]  red_byte
);

	// returns {source base coordinate, fraction in thirds}
	function automatic logic [6:0] map_axis(input logic [5:0] d, input logic flip);
		logic [5:0]  dc;
		logic [5:0]  sc;
		logic [6:0]  s;
		logic [14:0] p;
		logic [4:0]  q;
		logic [6:0]  r;
		dc = (d > DEST_LAST) ? DEST_LAST : d;
		sc = flip ? DEST_LAST - dc : dc;
		s  = {sc, 1'b0};
		p  = {8'b0, s} * {7'b0, RECIP3};
		q  = p[13:9];
		r  = s - ({1'b0, q, 1'b0} + {2'b0, q});
		return {q, r[1:0]};
	endfunction

	logic en1, en2, en3, en4, en5;

	logic        v_s1;
	logic [1:0]  kind_s1;
	logic [8:0]  addr_s1;
	logic [15:0] data_s1;
	logic [4:0]  x0_s1, y0_s1;
	logic [1:0]  fx_s1, fy_s1;
	logic [11:0] oidx_s1;

	logic        v_s2;
	logic        pixel_s2;
	logic        pal_wr_s2;
	logic [3:0]  addr_s2;
	logic [14:0] data_s2;
	logic [1:0]  fx_s2, fy_s2;
	logic [11:0] oidx_s2;

	logic        v_s3;
	logic [1:0]  fx_s3, fy_s3;
	logic [11:0] oidx_s3;

	logic        v_s4;
	logic [11:0] oidx_s4;

	logic [6:0]  map_x, map_y;
	logic [5:0]  dxc, dyc;
	logic [11:0] oidx_in;
	bm_cmd_t     bm_cmd;
	pal_wr_t     pal_wr;
	nbr_idx_t    nbr_idx;
	nbr_color_t  nbr_color;

	// a stage advances when it is empty or the next one advances
	always_comb begin
		en5      = !out_valid || !out_stall;
		en4      = !v_s4 || en5;
		en3      = !v_s3 || en4;
		en2      = !v_s2 || en3;
		en1      = !v_s1 || en2;
		in_stall = !en1;
	end

	always_comb begin
		map_x   = map_axis(dest_x, flip_h);
		map_y   = map_axis(dest_y, flip_v);
		dxc     = (dest_x > DEST_LAST) ? DEST_LAST : dest_x;
		dyc     = (dest_y > DEST_LAST) ? DEST_LAST : dest_y;
		oidx_in = {6'b0, DEST_LAST - dyc} + {1'b0, dxc, 5'b0} + {2'b0, dxc, 4'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2 && pixel_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1 <= kind;
			addr_s1 <= address;
			data_s1 <= data;
			x0_s1   <= map_x[6:2];
			fx_s1   <= map_x[1:0];
			y0_s1   <= map_y[6:2];
			fy_s1   <= map_y[1:0];
			oidx_s1 <= oidx_in;
		end
		if (en2) begin
			pixel_s2  <= kind_s1 == KIND_PIXEL;
			pal_wr_s2 <= kind_s1 == KIND_PALETTE && addr_s1[8:4] == 5'd0;
			addr_s2   <= addr_s1[3:0];
			data_s2   <= data_s1[14:0];
			fx_s2     <= fx_s1;
			fy_s2     <= fy_s1;
			oidx_s2   <= oidx_s1;
		end
		if (en3) begin
			fx_s3   <= fx_s2;
			fy_s3   <= fy_s2;
			oidx_s3 <= oidx_s2;
		end
		if (en4) oidx_s4 <= oidx_s3;
		if (en5) out_index <= oidx_s4;
	end

	always_comb begin
		bm_cmd.wr_en   = v_s1 && kind_s1 == KIND_BITMAP;
		bm_cmd.wr_addr = addr_s1;
		bm_cmd.wr_data = data_s1[7:0];
		bm_cmd.x0      = x0_s1;
		bm_cmd.x1      = (x0_s1 == SRC_LAST) ? SRC_LAST : x0_s1 + 5'd1;
		bm_cmd.y0      = y0_s1;
		bm_cmd.y1      = (y0_s1 == SRC_LAST) ? SRC_LAST : y0_s1 + 5'd1;
		pal_wr.wr_en   = v_s2 && pal_wr_s2;
		pal_wr.wr_addr = addr_s2;
		pal_wr.wr_data = data_s2;
	end

	tibu_bitmap u_bitmap (
		.clk (clk),
		.en  (en2),
		.cmd (bm_cmd),
		.idx (nbr_idx)
	);

	tibu_palette u_palette (
		.clk   (clk),
		.en    (en3),
		.wr    (pal_wr),
		.idx   (nbr_idx),
		.color (nbr_color)
	);

	tibu_blend u_blend (
		.clk        (clk),
		.en_sum     (en4),
		.en_out     (en5),
		.color      (nbr_color),
		.fx         (fx_s3),
		.fy         (fy_s3),
		.blue_byte  (blue_byte),
		.green_byte (green_byte),
		.red_byte   (red_byte)
	);

	// input only stalls when every stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && out_valid))
		else $error("input stalled with an empty stage");

	// a held item in stage four keeps its index
	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !en4) |=> (v_s4 && $stable(oidx_s4)))
		else $error("stage four item lost while held");

	// a taken result with nothing behind it leaves the output empty
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !v_s4) |=> !out_valid)
		else $error("result repeated after it was taken");

	// only pixel requests reach stage three
	a_s3_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(en3 && v_s2 && !pixel_s2) |=> !v_s3)
		else $error("write item passed into the blend stages");

endmodule

@@ rtl/core/tibu_bitmap.sv @@
// Icon bitmap in four banks, one neighbor byte per bank per enabled cycle, nibble select.
module tibu_bitmap import tibu_pkg::*; (
	input  logic     clk,
	input  logic     en,
	input  bm_cmd_t  cmd,
	output nbr_idx_t idx
);

	// bank = {row parity, byte column parity}
	logic [1:0][4:0] row_sel;
	logic [1:0][3:0] col_sel;
	logic [1:0]      wr_bank;
	logic [6:0]      wr_addr;
	logic [7:0]      rd_data_q [4];
	logic [1:0]      x0_q;
	logic [1:0]      x1_q;
	logic            y0_q;
	logic            y1_q;
	logic [7:0]      byte0, byte1, byte2, byte3;

	always_comb begin
		row_sel[0] = cmd.y0[0] ? cmd.y1 : cmd.y0;
		row_sel[1] = cmd.y0[0] ? cmd.y0 : cmd.y1;
		col_sel[0] = cmd.x0[1] ? cmd.x1[4:1] : cmd.x0[4:1];
		col_sel[1] = cmd.x0[1] ? cmd.x0[4:1] : cmd.x1[4:1];
		wr_bank    = {cmd.wr_addr[2], cmd.wr_addr[0]};
		wr_addr    = {cmd.wr_addr[8:3], cmd.wr_addr[1]};
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [7:0] mem [128];
		logic [6:0] rd_addr;

		assign rd_addr = {row_sel[b / 2][4:3], col_sel[b % 2][3:2],
			row_sel[b / 2][2:1], col_sel[b % 2][1]};

		always_ff @(posedge clk) begin
			if (en) begin
				if (cmd.wr_en && wr_bank == 2'(b)) begin
					mem[wr_addr] <= cmd.wr_data;
				end
				rd_data_q[b] <= mem[rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x0_q <= cmd.x0[1:0];
			x1_q <= cmd.x1[1:0];
			y0_q <= cmd.y0[0];
			y1_q <= cmd.y1[0];
		end
	end

	always_comb begin
		byte0  = rd_data_q[{y0_q, x0_q[1]}];
		byte1  = rd_data_q[{y0_q, x1_q[1]}];
		byte2  = rd_data_q[{y1_q, x0_q[1]}];
		byte3  = rd_data_q[{y1_q, x1_q[1]}];
		idx[0] = x0_q[0] ? byte0[7:4] : byte0[3:0];
		idx[1] = x1_q[0] ? byte1[7:4] : byte1[3:0];
		idx[2] = x0_q[0] ? byte2[7:4] : byte2[3:0];
		idx[3] = x1_q[0] ? byte3[7:4] : byte3[3:0];
	end

endmodule

@@ rtl/core/tibu_palette.sv @@
// Palette, one copy per neighbor so all four colors are read in each enabled cycle.
module tibu_palette import tibu_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  pal_wr_t    wr,
	input  nbr_idx_t   idx,
	output nbr_color_t color
);

	logic [14:0] rd_q [4];

	for (genvar c = 0; c < 4; c++) begin : g_copy
		logic [14:0] mem [16];

		always_ff @(posedge clk) begin
			if (en) begin
				if (wr.wr_en) begin
					mem[wr.wr_addr] <= wr.wr_data;
				end
				rd_q[c] <= mem[idx[c]];
			end
		end

		assign color[c] = rd_q[c];
	end

endmodule

@@ rtl/core/tibu_blend.sv @@
// Bilinear weighting in ninths, divide by nine, widen channels to bytes.
module tibu_blend import tibu_pkg::*; (
	input  logic       clk,
	input  logic       en_sum,
	input  logic       en_out,
	input  nbr_color_t color,
	input  logic [1:0] fx,
	input  logic [1:0] fy,
	output logic [7:0] blue_byte,
	output logic [7:0] green_byte,
	output logic [7:0] red_byte
);

	logic [1:0]      ax, ay;
	logic [3:0][3:0] w;
	logic [8:0]      r_sum, g_sum, b_sum;
	logic [8:0]      r_sum_s4, g_sum_s4, b_sum_s4;
	logic [13:0]     r_prod, g_prod, b_prod;
	logic [4:0]      r_q, g_q, b_q;

	always_comb begin
		ax   = 2'd3 - fx;
		ay   = 2'd3 - fy;
		w[0] = {2'b0, ax} * {2'b0, ay};
		w[1] = {2'b0, fx} * {2'b0, ay};
		w[2] = {2'b0, ax} * {2'b0, fy};
		w[3] = {2'b0, fx} * {2'b0, fy};
		r_sum = '0;
		g_sum = '0;
		b_sum = '0;
		for (int k = 0; k < 4; k++) begin
			r_sum = r_sum + {4'b0, color[k][4:0]}   * {5'b0, w[k]};
			g_sum = g_sum + {4'b0, color[k][9:5]}   * {5'b0, w[k]};
			b_sum = b_sum + {4'b0, color[k][14:10]} * {5'b0, w[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en_sum) begin
			r_sum_s4 <= r_sum;
			g_sum_s4 <= g_sum;
			b_sum_s4 <= b_sum;
		end
	end

	always_comb begin
		r_prod = {5'b0, r_sum_s4} * {8'b0, RECIP9};
		g_prod = {5'b0, g_sum_s4} * {8'b0, RECIP9};
		b_prod = {5'b0, b_sum_s4} * {8'b0, RECIP9};
		r_q    = r_prod[13:9];
		g_q    = g_prod[13:9];
		b_q    = b_prod[13:9];
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			blue_byte  <= {b_q, 3'b000};
			green_byte <= {g_q, g_q[4], 2'b00};
			red_byte   <= {r_q, 3'b000};
		end
	end

endmodule
